// ===== hdl/rk4ap_pkg.sv =====
package rk4ap_pkg;

  // field widths of the channels
  localparam int VEL_W      = 32;
  localparam int HGT_W      = 32;
  localparam int BRAKE_W    = 2;
  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 16;
  localparam int GAIN_W     = 32;
  localparam int DT_W       = 16;
  localparam int GRAV_W     = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DRAG_CLOSED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAG_PARTIAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAG_FULL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT   = 3'd5;

  // configuration reset values
  localparam logic [GAIN_W-1:0]  RST_DRAG_CLOSED  = 32'd1344772;
  localparam logic [GAIN_W-1:0]  RST_DRAG_PARTIAL = 32'd274443716;
  localparam logic [GAIN_W-1:0]  RST_DRAG_FULL    = 32'd548887432;
  localparam logic [DT_W-1:0]    RST_TIME_STEP    = 16'd655;
  localparam logic [GRAV_W-1:0]  RST_GRAVITY      = 23'd642908;
  localparam logic [COUNT_W-1:0] RST_STEP_LIMIT   = 16'd4096;

endpackage

// ===== hdl/rk4ap_in_if.sv =====
interface rk4ap_in_if;
  import rk4ap_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VEL_W-1:0]   start_velocity;
  logic signed [HGT_W-1:0]   start_height;
  logic        [BRAKE_W-1:0] brake_setting;

  modport source (output valid, start_velocity, start_height, brake_setting, input ready);
  modport sink (input valid, start_velocity, start_height, brake_setting, output ready);
endinterface

// ===== hdl/rk4ap_out_if.sv =====
interface rk4ap_out_if;
  import rk4ap_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [HGT_W-1:0]   apogee_height;
  logic        [TIME_W-1:0]  apogee_time;
  logic        [COUNT_W-1:0] step_count;
  logic signed [VEL_W-1:0]   end_velocity;
  logic                      limit_hit;

  modport source (output valid, apogee_height, apogee_time, step_count, end_velocity,
                  limit_hit, input ready);
  modport sink (input valid, apogee_height, apogee_time, step_count, end_velocity,
                limit_hit, output ready);
endinterface

// ===== hdl/rk4ap_cfg_if.sv =====
interface rk4ap_cfg_if;
  import rk4ap_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/rk4_apogee_predictor.sv =====
// each rk4 step runs on one shared 35x32 multiplier and a radix-16 divide-by-3
// the next input is taken once the result is parked in the output register, which
// waits while an earlier result is unread
// reset: synchronous active-low rst_n clears the sequencer and output valid and loads
// the configuration registers with their defaults
module rk4_apogee_predictor #(
  parameter int FRAC_BITS      = 16,
  parameter int BRAKE_SETTINGS = 3
) (
  input logic        clk,
  input logic        rst_n,
  rk4ap_in_if.sink   in_chan,
  rk4ap_out_if.source out_chan,
  rk4ap_cfg_if.sink  cfg_chan
);
  import rk4ap_pkg::*;

  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int DIV_W   = 36;
  localparam int DIV_DIGITS = DIV_W / 4;
  localparam int DIV_CNT_W  = $clog2(DIV_DIGITS);
  localparam int TSHL = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int TSHR = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam logic [BRAKE_W-1:0] BRAKE_TOP =
    BRAKE_W'((BRAKE_SETTINGS < 3) ? BRAKE_SETTINGS - 1 : 2);
  localparam logic [PROD_W-1:0] M_CAP = PROD_W'(64'h80000000);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_MAG, S_SQR, S_DHI, S_DSUM, S_VMUL, S_VUPD,
    S_MMUL, S_HMUL, S_DIVV, S_DIVH, S_TIME, S_FINISH
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [37:0] x);
    logic signed [31:0] y;
    if (x > 38'sh007FFFFFFF) y = 32'sh7FFFFFFF;
    else if (x < -38'sh0080000000) y = -32'sh80000000;
    else y = x[31:0];
    return y;
  endfunction

  // configuration registers
  logic [GAIN_W-1:0]  gain_closed_r, gain_partial_r, gain_full_r;
  logic [DT_W-1:0]    dt_r;
  logic [GRAV_W-1:0]  gravity_r;
  logic [COUNT_W-1:0] step_limit_r;

  // sequencer and datapath registers
  state_t                   state_r;
  logic [1:0]               stage_r;
  logic signed [31:0]       v_r, h_r;
  logic signed [33:0]       u_r;
  logic signed [35:0]       hs_r;
  logic                     hs_neg_r;
  logic [33:0]              msum_r;
  logic [31:0]              m_r, k_r, hi_r, dlo_r;
  logic [COUNT_W-1:0]       count_r;
  logic [PROD_W-1:0]        p_r;
  logic [DIV_W-1:0]         div_r;
  logic [1:0]               div_rem_r;
  logic [DIV_CNT_W-1:0]     div_cnt_r;

  // output register
  logic                     out_valid_r;
  logic signed [HGT_W-1:0]  out_height_r;
  logic [TIME_W-1:0]        out_time_r;
  logic [COUNT_W-1:0]       out_count_r;
  logic signed [VEL_W-1:0]  out_vel_r;
  logic                     out_limit_r;

  // combinational datapath
  logic                     mul_en;
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic [BRAKE_W-1:0]       brake_sel;
  logic [GAIN_W-1:0]        gain_sel;
  logic [33:0]              u_abs;
  logic [31:0]              mag;
  logic [PROD_W-1:0]        sq, m_full, ofs;
  logic [31:0]              m_sat;
  logic signed [33:0]       u_new;
  logic signed [35:0]       u_ext, hs_nxt;
  logic [33:0]              msum_nxt;
  logic [34:0]              hs_abs;
  logic [PROD_W-1:0]        num_rnd;
  logic [DIV_W-1:0]         div_load, div_shift;
  logic [1:0]               div_rem_nxt;
  logic [2:0]               div_x;
  logic [3:0]               div_q;
  logic signed [31:0]       v_upd, h_upd;
  logic [47:0]              t_shl, t_wide;
  logic [TIME_W-1:0]        t_sat;
  logic                     v_pos, in_xfer, out_xfer;

  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign out_xfer = out_valid_r && out_chan.ready;
  assign v_pos    = !v_r[31] && (v_r != '0);

  // brake setting saturates to the highest available gain
  always_comb begin
    brake_sel = (in_chan.brake_setting > BRAKE_TOP) ? BRAKE_TOP : in_chan.brake_setting;
    case (brake_sel)
      2'd0:    gain_sel = gain_closed_r;
      2'd1:    gain_sel = gain_partial_r;
      default: gain_sel = gain_full_r;
    endcase
  end

  // drag, stage velocity and accumulator arithmetic
  always_comb begin
    u_abs = u_r[33] ? 34'(-u_r) : 34'(u_r);
    mag   = (u_abs > 34'h080000000) ? 32'h80000000 : u_abs[31:0];
    sq    = p_r >> FRAC_BITS;
    m_full = p_r + PROD_W'(dlo_r) + PROD_W'(gravity_r);
    m_sat  = (m_full > M_CAP) ? 32'h80000000 : m_full[31:0];
    if (stage_r == 2'd2) ofs = (p_r + PROD_W'(1 << 15)) >> 16;
    else ofs = (p_r + PROD_W'(1 << 16)) >> 17;
    u_new = 34'(v_r) - $signed(ofs[33:0]);
    u_ext = 36'(u_r);
    case (stage_r)
      2'd0:    hs_nxt = u_ext;
      2'd3:    hs_nxt = hs_r + u_ext;
      default: hs_nxt = hs_r + (u_ext <<< 1);
    endcase
    case (stage_r)
      2'd0:    msum_nxt = 34'(m_r);
      2'd3:    msum_nxt = msum_r + 34'(m_r);
      default: msum_nxt = msum_r + (34'(m_r) << 1);
    endcase
    hs_abs   = hs_r[35] ? 35'(-hs_r) : 35'(hs_r);
    num_rnd  = p_r + PROD_W'(3 << 16);
    div_load = num_rnd[52:17];
  end

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_MAG: begin
        mul_a = MUL_A_W'(mag);
        mul_b = mag;
      end
      S_SQR: begin
        mul_a = MUL_A_W'(sq[31:0]);
        mul_b = k_r;
      end
      S_DHI: begin
        mul_a = MUL_A_W'(hi_r);
        mul_b = k_r;
      end
      S_VMUL: begin
        mul_a = MUL_A_W'(m_r);
        mul_b = MUL_B_W'(dt_r);
      end
      S_MMUL: begin
        mul_a = MUL_A_W'(msum_r);
        mul_b = MUL_B_W'(dt_r);
      end
      S_HMUL: begin
        mul_a = hs_abs;
        mul_b = MUL_B_W'(dt_r);
      end
      S_TIME: begin
        mul_a = MUL_A_W'(count_r);
        mul_b = MUL_B_W'(dt_r);
      end
      default: mul_en = 1'b0;
    endcase
  end

  // divide by three, four quotient bits per cycle
  always_comb begin
    div_rem_nxt = div_rem_r;
    div_q = '0;
    div_x = '0;
    for (int i = 0; i < 4; i++) begin
      div_x = {div_rem_nxt, div_r[DIV_W-1-i]};
      if (div_x >= 3'd3) begin
        div_rem_nxt = 2'(div_x - 3'd3);
        div_q[3-i]  = 1'b1;
      end else begin
        div_rem_nxt = div_x[1:0];
      end
    end
    div_shift = {div_r[DIV_W-5:0], div_q};
    v_upd = sat32(38'(v_r) - $signed({2'b00, div_shift}));
    if (hs_neg_r) h_upd = sat32(38'(h_r) - $signed({2'b00, div_shift}));
    else h_upd = sat32(38'(h_r) + $signed({2'b00, div_shift}));
  end

  // elapsed time, rescaled to the velocity format and saturated
  always_comb begin
    t_shl  = p_r[47:0] << TSHL;
    t_wide = t_shl >> TSHR;
    t_sat  = (t_wide[47:32] != '0) ? '1 : t_wide[31:0];
  end

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      gain_closed_r  <= RST_DRAG_CLOSED;
      gain_partial_r <= RST_DRAG_PARTIAL;
      gain_full_r    <= RST_DRAG_FULL;
      dt_r           <= RST_TIME_STEP;
      gravity_r      <= RST_GRAVITY;
      step_limit_r   <= RST_STEP_LIMIT;
    end else begin
      // configuration transfer
      if (cfg_chan.valid) begin
        case (cfg_chan.index)
          CFG_DRAG_CLOSED:  gain_closed_r  <= cfg_chan.data;
          CFG_DRAG_PARTIAL: gain_partial_r <= cfg_chan.data;
          CFG_DRAG_FULL:    gain_full_r    <= cfg_chan.data;
          CFG_TIME_STEP:    dt_r           <= cfg_chan.data[DT_W-1:0];
          CFG_GRAVITY:      gravity_r      <= cfg_chan.data[GRAV_W-1:0];
          CFG_STEP_LIMIT:   step_limit_r   <= cfg_chan.data[COUNT_W-1:0];
          default: ;
        endcase
      end

      if (mul_en) p_r <= mul_a * mul_b;
      // a result finishing in this cycle refills the register instead
      if (out_xfer && (state_r != S_FINISH)) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            v_r     <= in_chan.start_velocity;
            h_r     <= in_chan.start_height;
            k_r     <= gain_sel;
            count_r <= '0;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          stage_r <= 2'd0;
          u_r     <= 34'(v_r);
          if (v_pos && (count_r < step_limit_r)) state_r <= S_MAG;
          else state_r <= S_TIME;
        end
        S_MAG: begin
          hs_r    <= hs_nxt;
          state_r <= S_SQR;
        end
        S_SQR: begin
          hi_r    <= sq[63:32];
          state_r <= S_DHI;
        end
        S_DHI: begin
          dlo_r   <= p_r[63:32];
          state_r <= S_DSUM;
        end
        S_DSUM: begin
          m_r     <= m_sat;
          state_r <= S_VMUL;
        end
        S_VMUL: begin
          msum_r  <= msum_nxt;
          state_r <= (stage_r == 2'd3) ? S_MMUL : S_VUPD;
        end
        S_VUPD: begin
          u_r     <= u_new;
          stage_r <= stage_r + 2'd1;
          state_r <= S_MAG;
        end
        S_MMUL: begin
          state_r <= S_HMUL;
        end
        S_HMUL: begin
          // velocity drop numerator goes to the divider, height product starts
          div_r     <= div_load;
          div_rem_r <= '0;
          div_cnt_r <= '0;
          hs_neg_r  <= hs_r[35];
          state_r   <= S_DIVV;
        end
        S_DIVV: begin
          if (div_cnt_r == DIV_CNT_W'(DIV_DIGITS - 1)) begin
            v_r       <= v_upd;
            div_r     <= div_load;
            div_rem_r <= '0;
            div_cnt_r <= '0;
            state_r   <= S_DIVH;
          end else begin
            div_r     <= div_shift;
            div_rem_r <= div_rem_nxt;
            div_cnt_r <= div_cnt_r + 1'b1;
          end
        end
        S_DIVH: begin
          div_r     <= div_shift;
          div_rem_r <= div_rem_nxt;
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == DIV_CNT_W'(DIV_DIGITS - 1)) begin
            h_r     <= h_upd;
            count_r <= count_r + 1'b1;
            state_r <= S_CHECK;
          end
        end
        S_TIME: begin
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          // park the result once the output register is free
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r  <= 1'b1;
            out_height_r <= h_r;
            out_time_r   <= t_sat;
            out_count_r  <= count_r;
            out_vel_r    <= v_r;
            out_limit_r  <= v_pos;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_chan.ready          = (state_r == S_IDLE);
  assign cfg_chan.ready         = 1'b1;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.apogee_height = out_height_r;
  assign out_chan.apogee_time   = out_time_r;
  assign out_chan.step_count    = out_count_r;
  assign out_chan.end_velocity  = out_vel_r;
  assign out_chan.limit_hit     = out_limit_r;

`ifndef ASSERT_OFF
  a_limit_matches_velocity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_limit_r == (!out_vel_r[31] && (out_vel_r != '0))))
    else $error("limit flag disagrees with end velocity");

  a_decel_capped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VMUL) |-> (m_r <= 32'h80000000))
    else $error("deceleration magnitude above cap");

  a_div_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIVV) || (state_r == S_DIVH)) |-> (div_cnt_r < DIV_CNT_W'(DIV_DIGITS)))
    else $error("divider digit count out of range");

  a_accept_starts_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_CHECK))
    else $error("input transfer did not start a prediction");
`endif

endmodule
